/* src/assert_macros.svh */
// assertion macros for the rtl file ducu_back, which checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

/* src/ducu_pkg.sv */
// shared widths, codes and types of the decimal up/down counter
package ducu_pkg;

   localparam int NUM_DIGITS   = 4;
   localparam int COUNT_DIGITS = 4;
   localparam int COUNT_W      = 14;
   localparam int FUNC_W       = 2;
   localparam int CHAR_W       = 8;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [FUNC_W-1:0] FUNC_RX   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DOWN = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_UP   = 2'd2;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;

   typedef logic [COUNT_DIGITS-1:0][3:0] digits_type;

   typedef struct packed {
      digits_type         digits;
      logic [COUNT_W-1:0] value;
   } entry_type;

endpackage

/* src/ducu_channels.sv */
// request and response channel interfaces
interface ducu_req_if;
   logic                         valid;
   logic                         ready;
   logic [ducu_pkg::FUNC_W-1:0]  func;
   logic [ducu_pkg::CHAR_W-1:0]  rx_char;

   modport source (output valid, func, rx_char, input ready);
   modport sink (input valid, func, rx_char, output ready);
endinterface

interface ducu_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ducu_pkg::CHAR_W-1:0]  tx_char;
   logic                         last;
   logic [ducu_pkg::COUNT_W-1:0] count_value;

   modport source (output valid, tx_char, last, count_value, input ready);
   modport sink (input valid, tx_char, last, count_value, output ready);
endinterface

/* src/ducu_queue.sv */
// short queue of pending reports between front and back
module ducu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ducu_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output ducu_pkg::entry_type head_entry
);

   localparam int DEPTH = ducu_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ducu_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* src/ducu_front.sv */
// front end: takes requests, runs the word matcher and updates the counter
module ducu_front (
   input  logic                clock,
   input  logic                reset,
   ducu_req_if.sink            req_bus,
   input  logic                queue_full,
   output logic                push,
   output ducu_pkg::entry_type push_entry
);

   localparam int WORD_LEN = 5;
   localparam int MATCH_W  = 3;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_DOWN  = 2'd1,
      OP_UP    = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   logic [ducu_pkg::COUNT_W-1:0] count_ff, count_in;
   ducu_pkg::digits_type         digits_ff, digits_in;
   logic [MATCH_W-1:0]           match_ff, match_in;
   logic                         accept;
   logic                         hit;
   op_type                       op;

   // expected character at each place of "Reset"
   function automatic logic [ducu_pkg::CHAR_W-1:0] word_char(input logic [MATCH_W-1:0] idx);
      unique case (idx)
         3'd0:    word_char = 8'h52;
         3'd1:    word_char = 8'h65;
         3'd2:    word_char = 8'h73;
         3'd3:    word_char = 8'h65;
         3'd4:    word_char = 8'h74;
         default: word_char = 8'h00;
      endcase
   endfunction

   function automatic ducu_pkg::digits_type bcd_up(input ducu_pkg::digits_type d);
      ducu_pkg::digits_type r;
      logic                 carry;
      carry = 1'b1;
      r     = d;
      for (int k = 0; k < ducu_pkg::COUNT_DIGITS; k++) begin
         if (carry) begin
            if (d[k] == 4'd9) begin
               r[k] = 4'd0;
            end else begin
               r[k]  = d[k] + 4'd1;
               carry = 1'b0;
            end
         end
      end
      bcd_up = r;
   endfunction

   function automatic ducu_pkg::digits_type bcd_down(input ducu_pkg::digits_type d);
      ducu_pkg::digits_type r;
      logic                 borrow;
      borrow = 1'b1;
      r      = d;
      for (int k = 0; k < ducu_pkg::COUNT_DIGITS; k++) begin
         if (borrow) begin
            if (d[k] == 4'd0) begin
               r[k] = 4'd9;
            end else begin
               r[k]   = d[k] - 4'd1;
               borrow = 1'b0;
            end
         end
      end
      bcd_down = r;
   endfunction

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      hit      = (match_ff < MATCH_W'(WORD_LEN)) && (req_bus.rx_char == word_char(match_ff));
      op       = OP_NONE;
      match_in = match_ff;
      if (req_bus.func == ducu_pkg::FUNC_DOWN) begin
         op = OP_DOWN;
      end else if (req_bus.func == ducu_pkg::FUNC_UP) begin
         op = OP_UP;
      end else if (req_bus.func == ducu_pkg::FUNC_RX) begin
         if (hit && match_ff == MATCH_W'(WORD_LEN - 1)) begin
            op       = OP_CLEAR;
            match_in = '0;
         end else begin
            match_in = hit ? match_ff + MATCH_W'(1) : '0;
            if (req_bus.rx_char == 8'h64 || req_bus.rx_char == 8'h44) begin
               op = OP_DOWN;
            end else if (req_bus.rx_char == 8'h75 || req_bus.rx_char == 8'h55) begin
               op = OP_UP;
            end
         end
      end

      unique case (op)
         OP_NONE: begin
            count_in  = count_ff;
            digits_in = digits_ff;
         end
         OP_DOWN: begin
            count_in  = (count_ff == '0) ? ducu_pkg::COUNT_W'(9999)
                                         : count_ff - ducu_pkg::COUNT_W'(1);
            digits_in = bcd_down(digits_ff);
         end
         OP_UP: begin
            count_in  = (count_ff == ducu_pkg::COUNT_W'(9999)) ? '0
                                         : count_ff + ducu_pkg::COUNT_W'(1);
            digits_in = bcd_up(digits_ff);
         end
         OP_CLEAR: begin
            count_in  = '0;
            digits_in = '0;
         end
      endcase
   end

   assign push              = accept && (op != OP_NONE);
   assign push_entry.value  = count_in;
   assign push_entry.digits = digits_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         digits_ff <= '0;
         match_ff  <= '0;
      end else if (accept) begin
         count_ff  <= count_in;
         digits_ff <= digits_in;
         match_ff  <= match_in;
      end
   end

endmodule

/* src/ducu_back.sv */
// back end: sends one report byte per cycle through the output register unless the response channel stalls
`include "assert_macros.svh"

module ducu_back #(
   parameter int NUM_DIGITS = ducu_pkg::NUM_DIGITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  ducu_pkg::entry_type head_entry,
   output logic                pop,
   ducu_rsp_if.source          rsp_bus
);

   localparam int LAST_IDX = NUM_DIGITS + 1;
   localparam int IDX_W    = $clog2(NUM_DIGITS + 2);

   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic                            rsp_valid_ff;
   logic [ducu_pkg::CHAR_W-1:0]     tx_ff, tx_in;
   logic                            last_ff;
   logic [ducu_pkg::COUNT_W-1:0]    value_ff;
   logic                            advance;
   logic                            emit;
   logic                            at_last;
   logic [3:0]                      digit;

   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign emit    = advance && head_valid;
   assign at_last = (idx_ff == IDX_W'(LAST_IDX));
   assign pop     = emit && at_last;
   assign idx_in  = at_last ? '0 : idx_ff + IDX_W'(1);

   always_comb begin
      // slots above the stored digits are leading zeros
      digit = 4'd0;
      for (int k = 0; k < ducu_pkg::COUNT_DIGITS; k++) begin
         if (k < NUM_DIGITS) begin
            if (idx_ff == IDX_W'(NUM_DIGITS - 1 - k)) begin
               digit = head_entry.digits[k];
            end
         end
      end
      if (idx_ff < IDX_W'(NUM_DIGITS)) begin
         tx_in = ducu_pkg::ASCII_ZERO + {4'd0, digit};
      end else if (idx_ff == IDX_W'(NUM_DIGITS)) begin
         tx_in = ducu_pkg::CHAR_LF;
      end else begin
         tx_in = ducu_pkg::CHAR_CR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (advance) begin
         rsp_valid_ff <= head_valid;
         if (head_valid) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         tx_ff    <= tx_in;
         last_ff  <= at_last;
         value_ff <= head_entry.value;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.tx_char     = tx_ff;
   assign rsp_bus.last        = last_ff;
   assign rsp_bus.count_value = value_ff;

   `ASSERT_NEVER(pop_without_head, pop && !head_valid, "report popped from empty queue")
   `ASSERT_HOLDS(index_wraps, (pop |=> idx_ff == '0), "byte index did not wrap after cr")
   `ASSERT_HOLDS(emit_fills_out, (emit |=> rsp_valid_ff), "emitted byte not presented")

endmodule

/* src/decimal_updown_counter_uart_unit.sv */
// top level of the decimal up/down counter with serial report
//
//   channel   dir   payload                          handshake
//   req_bus   in    func, rx_char                    valid/ready
//   rsp_bus   out   tx_char, last, count_value       valid/ready
//
// - a request is taken every cycle while the two-entry report queue has room
// - each counter change yields NUM_DIGITS + 2 response bytes (6 at the default
//   width), one per cycle while the response channel is ready, so the byte
//   emitter in the back end sets the rate of counting requests
// - requests that change nothing give no report and no bytes
// - synchronous reset clears the counter, the matcher, the queue and the emitter
// - a stalled response holds its byte while the front keeps taking requests
//   until the report queue is full
module decimal_updown_counter_uart_unit #(
   parameter int NUM_DIGITS = ducu_pkg::NUM_DIGITS
) (
   input  logic        clock,
   input  logic        reset,
   ducu_req_if.sink    req_bus,
   ducu_rsp_if.source  rsp_bus
);

   // front to queue
   logic                push;
   ducu_pkg::entry_type push_entry;
   logic                queue_full;

   // queue to back
   logic                head_valid;
   ducu_pkg::entry_type head_entry;
   logic                pop;

   // request decode, word matcher, binary and bcd counters
   ducu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // pending reports, lets front and back stall apart
   ducu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // digit, lf and cr sequencing into the response register
   ducu_back #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

/* dv/tb_decimal_updown_counter_uart_unit.sv */
// testbench for the decimal up/down counter with serial report
module tb_decimal_updown_counter_uart_unit;
   import ducu_pkg::*;

   // func code that the block must ignore
   localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

   // characters the block reacts to
   localparam logic [CHAR_W-1:0] CHAR_UP_LOWER   = "u";
   localparam logic [CHAR_W-1:0] CHAR_UP_UPPER   = "U";
   localparam logic [CHAR_W-1:0] CHAR_DOWN_LOWER = "d";
   localparam logic [CHAR_W-1:0] CHAR_DOWN_UPPER = "D";

   // clear word, first character in the top byte
   localparam int                  WORD_LEN   = 5;
   localparam logic [8*WORD_LEN-1:0] CLEAR_WORD = "Reset";

   localparam logic [COUNT_W-1:0] COUNT_MAX = 14'd9999;

   localparam int REPORT_LEN   = NUM_DIGITS + 2;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_SHOWN    = 10;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CHAR_W-1:0] rx_char;
   } request_type;

   typedef struct packed {
      logic [CHAR_W-1:0]  tx_char;
      logic               last;
      logic [COUNT_W-1:0] count_value;
   } report_byte_type;

   // traffic phases, each with its own idling pattern
   typedef enum logic [2:0] {
      PH_STEADY,
      PH_SENDER_IDLE,
      PH_RECEIVER_STALL,
      PH_BOTH_IDLE,
      PH_BACKPRESSURE
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ducu_req_if req_bus ();
   ducu_rsp_if rsp_bus ();

   decimal_updown_counter_uart_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   // requests waiting to be offered, and report bytes waiting to arrive
   request_type     request_q[$];
   report_byte_type report_bytes_q[$];

   phase_type phase    = PH_STEADY;
   logic      hold_off = 1'b0;

   // shadow of the block state
   logic [COUNT_W-1:0] shadow_count = '0;
   logic [2:0]         shadow_match = '0;

   // bookkeeping for the summary and the verdict
   int queued_active  = 0;
   int accepted_total = 0;
   int ignored_total  = 0;
   int reports_total  = 0;
   int bytes_seen     = 0;
   int wraps_down     = 0;
   int wraps_up       = 0;
   int word_clears    = 0;
   int mismatch_count = 0;

   // ---------------------------------------------------------------
   // predictor: applies one request to the shadow state and queues
   // the report bytes that the change produces
   // ---------------------------------------------------------------
   task automatic count_down();
      if (shadow_count == 0 || shadow_count > COUNT_MAX) begin
         shadow_count = COUNT_MAX;
         wraps_down++;
      end else begin
         shadow_count = shadow_count - 1'b1;
      end
   endtask

   task automatic count_up();
      if (shadow_count >= COUNT_MAX) begin
         shadow_count = '0;
         wraps_up++;
      end else begin
         shadow_count = shadow_count + 1'b1;
      end
   endtask

   task automatic queue_report();
      logic [3:0]      digs [NUM_DIGITS];
      report_byte_type item;
      int              v;
      v = int'(shadow_count);
      // most significant digit first, low-order digits if narrower than 4
      for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
         digs[i] = 4'(v % 10);
         v = v / 10;
      end
      for (int i = 0; i < NUM_DIGITS; i++) begin
         item.tx_char     = ASCII_ZERO + CHAR_W'(digs[i]);
         item.last        = 1'b0;
         item.count_value = shadow_count;
         report_bytes_q.push_back(item);
      end
      item.tx_char = CHAR_LF;
      report_bytes_q.push_back(item);
      item.tx_char = CHAR_CR;
      item.last    = 1'b1;
      report_bytes_q.push_back(item);
      reports_total++;
   endtask

   task automatic count_and_report(input logic [FUNC_W-1:0] func,
                                   input logic [CHAR_W-1:0] ch);
      logic changed;
      logic cleared;
      changed = 1'b0;
      cleared = 1'b0;
      case (func)
         FUNC_DOWN: begin
            count_down();
            changed = 1'b1;
         end
         FUNC_UP: begin
            count_up();
            changed = 1'b1;
         end
         FUNC_RX: begin
            // a miss drops the matcher and is not retried as a new start
            if (shadow_match < WORD_LEN &&
                ch == CLEAR_WORD[8*(WORD_LEN-1-shadow_match) +: 8]) begin
               shadow_match = shadow_match + 1'b1;
               if (shadow_match == WORD_LEN) begin
                  shadow_count = '0;
                  shadow_match = '0;
                  word_clears++;
                  changed = 1'b1;
                  cleared = 1'b1;
               end
            end else begin
               shadow_match = '0;
            end
            if (!cleared) begin
               if (ch == CHAR_DOWN_LOWER || ch == CHAR_DOWN_UPPER) begin
                  count_down();
                  changed = 1'b1;
               end else if (ch == CHAR_UP_LOWER || ch == CHAR_UP_UPPER) begin
                  count_up();
                  changed = 1'b1;
               end
            end
         end
         default: ignored_total++;
      endcase
      if (changed) queue_report();
   endtask

   // ---------------------------------------------------------------
   // idling decisions per phase
   // ---------------------------------------------------------------
   function automatic logic sender_pause();
      case (phase)
         PH_SENDER_IDLE: return $urandom_range(99) < 88;
         PH_BOTH_IDLE:   return $urandom_range(99) < 10;
         default:        return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_pause();
      case (phase)
         PH_RECEIVER_STALL: return $urandom_range(99) < 88;
         PH_BOTH_IDLE:      return $urandom_range(99) < 10;
         default:           return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // driver: offers queued requests, runs the predictor on each
   // accepted request
   // ---------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      logic        taken;
      request_type next_req;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         taken = req_bus.valid && req_bus.ready;
         if (taken) begin
            accepted_total++;
            count_and_report(req_bus.func, req_bus.rx_char);
         end
         // a held request stays up until taken, without a drop in between
         if (!req_bus.valid || taken) begin
            if (request_q.size() != 0 && !sender_pause()) begin
               next_req = request_q.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.func    <= next_req.func;
               req_bus.rx_char <= next_req.rx_char;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: checks every report byte against the oldest expectation
   // ---------------------------------------------------------------
   task automatic log_mismatch(input string what, input report_byte_type want,
                               input report_byte_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN) begin
         $display("mismatch (%s): expected char %0d last %0d count %0d",
                  what, want.tx_char, want.last, want.count_value);
         $display("   got char %0d last %0d count %0d",
                  got.tx_char, got.last, got.count_value);
      end
   endtask

   always @(posedge clock) begin : report_monitor
      report_byte_type want;
      report_byte_type got;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            bytes_seen++;
            got.tx_char     = rsp_bus.tx_char;
            got.last        = rsp_bus.last;
            got.count_value = rsp_bus.count_value;
            if (report_bytes_q.size() == 0) begin
               log_mismatch("no byte expected", '0, got);
            end else begin
               want = report_bytes_q.pop_front();
               if (got.tx_char !== want.tx_char ||
                   got.last !== want.last ||
                   got.count_value !== want.count_value)
                  log_mismatch("wrong field", want, got);
            end
         end
         rsp_bus.ready <= !hold_off && !receiver_pause();
      end
   end

   // long receiver hold-off, timed in its own process
   initial begin : hold_off_timer
      wait (phase == PH_BACKPRESSURE);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   task automatic queue_request(input logic [FUNC_W-1:0] func,
                                input logic [CHAR_W-1:0] ch);
      request_type req;
      req.func    = func;
      req.rx_char = ch;
      request_q.push_back(req);
      if (func != FUNC_NONE) queued_active++;
   endtask

   task automatic queue_word(input string word);
      for (int i = 0; i < word.len(); i++) queue_request(FUNC_RX, word[i]);
   endtask

   task automatic queue_directed();
      // ignored selector, then both wraps at the ends of the range
      queue_request(FUNC_NONE, 8'hFF);
      queue_request(FUNC_DOWN, 8'h00);
      queue_request(FUNC_UP, 8'hFF);
      // all four counting characters
      queue_request(FUNC_RX, CHAR_DOWN_LOWER);
      queue_request(FUNC_RX, CHAR_DOWN_UPPER);
      queue_request(FUNC_RX, CHAR_UP_LOWER);
      queue_request(FUNC_RX, CHAR_UP_UPPER);
      // characters with no effect on the count
      queue_request(FUNC_RX, 8'h00);
      queue_request(FUNC_RX, 8'hFF);
      // full clear word
      queue_word("Reset");
      // a repeated first letter misses and does not restart the match
      queue_word("RReset");
      // button in the middle keeps the match going
      queue_word("Re");
      queue_request(FUNC_UP, 8'h55);
      queue_word("set");
      // miss on a counting character still counts
      queue_word("Ru");
   endtask

   function automatic logic [CHAR_W-1:0] counting_char();
      case ($urandom_range(3))
         0:       return CHAR_UP_LOWER;
         1:       return CHAR_UP_UPPER;
         2:       return CHAR_DOWN_LOWER;
         default: return CHAR_DOWN_UPPER;
      endcase
   endfunction

   function automatic logic [FUNC_W-1:0] any_button();
      return $urandom_range(1) ? FUNC_UP : FUNC_DOWN;
   endfunction

   task automatic queue_random_traffic(input int target);
      int start;
      int pick;
      int len;
      start = queued_active;
      while (queued_active - start < target) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            // clear word, sometimes with a button press inside
            for (int k = 0; k < WORD_LEN; k++) begin
               if ($urandom_range(9) == 0)
                  queue_request(any_button(), CHAR_W'($urandom_range(255)));
               queue_request(FUNC_RX, CLEAR_WORD[8*(WORD_LEN-1-k) +: 8]);
            end
         end else if (pick < 45) begin
            // clear word broken off by a stray character
            len = $urandom_range(1, WORD_LEN - 1);
            for (int k = 0; k < len; k++)
               queue_request(FUNC_RX, CLEAR_WORD[8*(WORD_LEN-1-k) +: 8]);
            queue_request(FUNC_RX, $urandom_range(1) ? counting_char()
                                                     : CHAR_W'($urandom_range(255)));
         end else if (pick < 65) begin
            queue_request(FUNC_RX, counting_char());
         end else if (pick < 80) begin
            queue_request(any_button(), CHAR_W'($urandom_range(255)));
         end else if (pick < 93) begin
            queue_request(FUNC_RX, CHAR_W'($urandom_range(255)));
         end else begin
            queue_request(FUNC_NONE, CHAR_W'($urandom_range(255)));
         end
      end
   endtask

   // every request here changes the count, so the report queue fills up
   task automatic queue_counting_burst(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(1)) queue_request(any_button(), CHAR_W'($urandom_range(255)));
         else queue_request(FUNC_RX, counting_char());
      end
   endtask

   // sampled away from the rising edge so the driver and monitor have settled
   task automatic wait_drained();
      while (request_q.size() != 0 || req_bus.valid || report_bytes_q.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------
   // run sequence
   // ---------------------------------------------------------------
   initial begin : run_sequence
      req_bus.valid   = 1'b0;
      req_bus.func    = FUNC_RX;
      req_bus.rx_char = '0;
      rsp_bus.ready   = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // no idling on either side
      phase = PH_STEADY;
      queue_directed();
      queue_random_traffic(55);
      wait_drained();

      phase = PH_SENDER_IDLE;
      queue_random_traffic(50);
      wait_drained();

      phase = PH_RECEIVER_STALL;
      queue_random_traffic(50);
      wait_drained();

      phase = PH_BOTH_IDLE;
      queue_random_traffic(50);
      wait_drained();

      // receiver held off while requests keep coming
      phase = PH_BACKPRESSURE;
      queue_counting_burst(30);
      wait_drained();

      // catch any stray bytes after the last report
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);

      if (report_bytes_q.size() != 0)
         $display("%0d report bytes never arrived", report_bytes_q.size());
      $display("run covered %0d requests (%0d ignored), %0d reports, %0d bytes checked",
               accepted_total, ignored_total, reports_total, bytes_seen);
      $display("wraps down %0d, wraps up %0d, clear words %0d, mismatches %0d",
               wraps_down, wraps_up, word_clears, mismatch_count);
      if (mismatch_count == 0 && report_bytes_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
